/* src/gone_pkg.sv */
package gone_pkg;

  localparam int GRID_SIDE = 64;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int CMD_W     = 3;

  // The map is held as one word per column, spread over three banks by
  // column modulo three, so that a column and both its neighbours can be
  // read in the same cycle.
  localparam int NBANKS     = 3;
  localparam int BANK_DEPTH = GRID_SIDE / NBANKS + 1;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int BANK_SEL_W = 2;

  // Division by three as a multiplication by a scaled reciprocal.
  localparam int DIV3_SHIFT = 14;
  localparam int DIV3_MUL   = (1 << DIV3_SHIFT) / 3 + 1;
  localparam int DIV3_PW    = COORD_W + DIV3_SHIFT;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY      = 3'd0,
    CMD_SET_START  = 3'd1,
    CMD_SET_DEST   = 3'd2,
    CMD_PLACE_BLK  = 3'd3,
    CMD_REMOVE_BLK = 3'd4,
    CMD_CLEAR_ALL  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [BANK_AW-1:0]    quot;
    logic [BANK_SEL_W-1:0] bank;
  } col_split_t;

  function automatic col_split_t split_col(input logic [COORD_W-1:0] c);
    logic [DIV3_PW-1:0] prod;
    logic [COORD_W-1:0] q_ext;
    col_split_t         s;
    prod   = DIV3_PW'(c) * DIV3_PW'(DIV3_MUL);
    s.quot = BANK_AW'(prod >> DIV3_SHIFT);
    q_ext  = COORD_W'(s.quot);
    s.bank = BANK_SEL_W'(c - q_ext - (q_ext << 1));
    return s;
  endfunction

  function automatic logic [BANK_SEL_W-1:0] bank_next(input logic [BANK_SEL_W-1:0] b);
    return (b == BANK_SEL_W'(NBANKS - 1)) ? '0 : BANK_SEL_W'(b + 1'b1);
  endfunction

  function automatic logic [BANK_SEL_W-1:0] bank_prev(input logic [BANK_SEL_W-1:0] b);
    return (b == '0) ? BANK_SEL_W'(NBANKS - 1) : BANK_SEL_W'(b - 1'b1);
  endfunction

endpackage

/* src/gone_intf.sv */
interface gone_in_if import gone_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;

  modport source (output valid, output command, output column, output row, input ready);
  modport sink   (input valid, input command, input column, input row, output ready);
endinterface

interface gone_out_if import gone_pkg::*;;
  logic               valid;
  logic               ready;
  logic [7:0]         neighbour_mask;
  logic               cell_blocked;
  logic               start_valid;
  logic [COORD_W-1:0] start_column;
  logic [COORD_W-1:0] start_row;
  logic               dest_valid;
  logic [COORD_W-1:0] dest_column;
  logic [COORD_W-1:0] dest_row;

  modport source (output valid, output neighbour_mask, output cell_blocked,
                  output start_valid, output start_column, output start_row,
                  output dest_valid, output dest_column, output dest_row,
                  input ready);
  modport sink   (input valid, input neighbour_mask, input cell_blocked,
                  input start_valid, input start_column, input start_row,
                  input dest_valid, input dest_column, input dest_row,
                  output ready);
endinterface

/* src/gone_bank_ram.sv */
module gone_bank_ram #(
  parameter int DEPTH = 22,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/grid_occupancy_neighbour_expand.sv */
// Occupancy grid with 8-neighbour expansion, 64 by 64 cells.
//
// Input channel in_ch carries a command, a column and a row per beat; the
// result channel out_ch returns one beat per input beat, in order: the
// reachable-neighbour mask of the addressed cell after the command, whether
// that cell is blocked, and the current start and destination cells.
//
// An accepted beat waits in the update stage, then in the result register.
// One beat is taken every cycle while out_ch.ready is high: the three
// column banks are read when a beat is accepted, and the updated column is
// written back as it leaves, bypassing a column written by the beat ahead.
//
// Reset clears the start and destination marks and the per-column valid
// bits, so the whole map reads as free at once; no clearing pass is needed.
// Clear all does the same, also with no clearing pass.
//
// When the receiver holds out_ch.ready low the result register keeps its
// beat, one further beat can wait in the update stage, and in_ch.ready then
// drops until the result is taken.
module grid_occupancy_neighbour_expand import gone_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  gone_in_if.sink   in_ch,
  gone_out_if.source out_ch
);

  logic       in_acc;
  col_split_t in_sp;
  logic [BANK_AW-1:0] rd_addr [NBANKS];
  logic [GRID_SIDE-1:0] rd_data [NBANKS];
  logic [NBANKS-1:0] wr_en;

  logic                  s1_valid_r;
  logic [CMD_W-1:0]      s1_cmd_r;
  logic [COORD_W-1:0]    s1_col_r;
  logic [COORD_W-1:0]    s1_row_r;
  logic [BANK_SEL_W-1:0] s1_bank_r;
  logic [BANK_AW-1:0]    s1_quot_r;
  logic                  s1_go;

  logic [GRID_SIDE-1:0] col_valid_r;
  logic [COORD_W-1:0]   byp_col_r;
  logic [GRID_SIDE-1:0] byp_data_r;

  logic               start_set_r, start_set_nxt;
  logic [COORD_W-1:0] start_col_r, start_col_nxt;
  logic [COORD_W-1:0] start_row_r, start_row_nxt;
  logic               dest_set_r, dest_set_nxt;
  logic [COORD_W-1:0] dest_col_r, dest_col_nxt;
  logic [COORD_W-1:0] dest_row_r, dest_row_nxt;

  logic [COORD_W-1:0]   col_l_idx, col_r_idx;
  logic [GRID_SIDE-1:0] col_l, col_c, col_rt, col_post;
  logic [GRID_SIDE-1:0] lw, cw, rw;
  logic [COORD_W-1:0]   row_up, row_dn;
  logic at_left, at_right, at_top, at_bot;
  logic cell_b, new_bit, start_hit, dest_hit, do_write, do_clear;
  logic [7:0] nb_mask;

  logic       out_valid_r;
  logic [7:0] out_mask_r;
  logic       out_blk_r;
  logic       out_sv_r, out_dv_r;
  logic [COORD_W-1:0] out_sc_r, out_sr_r, out_dc_r, out_dr_r;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_sp       = split_col(in_ch.column);

  // Each bank is read at whichever of the three columns falls into it.
  always_comb begin
    for (int b = 0; b < NBANKS; b++) begin
      if (BANK_SEL_W'(b) == in_sp.bank) begin
        rd_addr[b] = in_sp.quot;
      end else if (BANK_SEL_W'(b) == bank_next(in_sp.bank)) begin
        rd_addr[b] = (in_sp.bank == BANK_SEL_W'(NBANKS - 1)) ?
                     BANK_AW'(in_sp.quot + 1'b1) : in_sp.quot;
      end else begin
        if (in_sp.bank == '0) begin
          rd_addr[b] = (in_sp.quot == '0) ? '0 : BANK_AW'(in_sp.quot - 1'b1);
        end else begin
          rd_addr[b] = in_sp.quot;
        end
      end
    end
  end

  for (genvar b = 0; b < NBANKS; b++) begin : g_bank
    assign wr_en[b] = s1_go && do_write && (s1_bank_r == BANK_SEL_W'(b));
    gone_bank_ram #(
      .DEPTH (BANK_DEPTH),
      .WIDTH (GRID_SIDE)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr_en[b]),
      .wr_addr (s1_quot_r),
      .wr_data (col_post),
      .rd_en   (in_acc),
      .rd_addr (rd_addr[b]),
      .rd_data (rd_data[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_acc;
    end
    if (in_acc) begin
      s1_cmd_r  <= in_ch.command;
      s1_col_r  <= in_ch.column;
      s1_row_r  <= in_ch.row;
      s1_bank_r <= in_sp.bank;
      s1_quot_r <= in_sp.quot;
    end
  end

  assign col_l_idx = COORD_W'(s1_col_r - 1'b1);
  assign col_r_idx = COORD_W'(s1_col_r + 1'b1);
  assign row_up    = COORD_W'(s1_row_r - 1'b1);
  assign row_dn    = COORD_W'(s1_row_r + 1'b1);
  assign at_left   = (s1_col_r == '0);
  assign at_right  = (s1_col_r == COORD_W'(GRID_SIDE - 1));
  assign at_top    = (s1_row_r == '0);
  assign at_bot    = (s1_row_r == COORD_W'(GRID_SIDE - 1));

  // A column never written since reset or clear all reads as free. The bank
  // data may predate the write made by the previous beat, so that write is
  // taken from the bypass record instead.
  always_comb begin
    col_c  = '0;
    col_l  = '0;
    col_rt = '0;
    if (col_valid_r[s1_col_r]) begin
      col_c = (byp_col_r == s1_col_r) ? byp_data_r : rd_data[s1_bank_r];
    end
    if (col_valid_r[col_l_idx]) begin
      col_l = (byp_col_r == col_l_idx) ? byp_data_r : rd_data[bank_prev(s1_bank_r)];
    end
    if (col_valid_r[col_r_idx]) begin
      col_rt = (byp_col_r == col_r_idx) ? byp_data_r : rd_data[bank_next(s1_bank_r)];
    end
  end

  assign cell_b    = col_c[s1_row_r];
  assign start_hit = start_set_r && (start_col_r == s1_col_r) && (start_row_r == s1_row_r);
  assign dest_hit  = dest_set_r && (dest_col_r == s1_col_r) && (dest_row_r == s1_row_r);

  always_comb begin
    new_bit       = cell_b;
    do_write      = 1'b0;
    do_clear      = 1'b0;
    start_set_nxt = start_set_r;
    start_col_nxt = start_col_r;
    start_row_nxt = start_row_r;
    dest_set_nxt  = dest_set_r;
    dest_col_nxt  = dest_col_r;
    dest_row_nxt  = dest_row_r;
    case (s1_cmd_r)
      CMD_SET_START: begin
        do_write = 1'b1;
        if (!start_hit) begin
          if (cell_b) begin
            new_bit = 1'b0;
          end else if (dest_hit) begin
            dest_set_nxt = 1'b0;
            dest_col_nxt = '0;
            dest_row_nxt = '0;
          end
          start_set_nxt = 1'b1;
          start_col_nxt = s1_col_r;
          start_row_nxt = s1_row_r;
        end
      end
      CMD_SET_DEST: begin
        do_write = 1'b1;
        if (!dest_hit) begin
          if (cell_b) begin
            new_bit = 1'b0;
          end else if (start_hit) begin
            start_set_nxt = 1'b0;
            start_col_nxt = '0;
            start_row_nxt = '0;
          end
          dest_set_nxt = 1'b1;
          dest_col_nxt = s1_col_r;
          dest_row_nxt = s1_row_r;
        end
      end
      CMD_PLACE_BLK: begin
        do_write = 1'b1;
        if (!cell_b) begin
          if (start_hit) begin
            start_set_nxt = 1'b0;
            start_col_nxt = '0;
            start_row_nxt = '0;
          end else if (dest_hit) begin
            dest_set_nxt = 1'b0;
            dest_col_nxt = '0;
            dest_row_nxt = '0;
          end
          new_bit = 1'b1;
        end
      end
      CMD_REMOVE_BLK: begin
        do_write = 1'b1;
        new_bit  = 1'b0;
      end
      CMD_CLEAR_ALL: begin
        do_clear      = 1'b1;
        start_set_nxt = 1'b0;
        start_col_nxt = '0;
        start_row_nxt = '0;
        dest_set_nxt  = 1'b0;
        dest_col_nxt  = '0;
        dest_row_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    col_post           = col_c;
    col_post[s1_row_r] = new_bit;
  end

  assign lw = do_clear ? '0 : col_l;
  assign cw = do_clear ? '0 : col_post;
  assign rw = do_clear ? '0 : col_rt;

  // Bit order runs down the left column, then the centre, then the right.
  // A diagonal is refused when its cell is blocked or both cells beside it are.
  always_comb begin
    nb_mask[0] = !at_left && !at_top && !lw[row_up] && !(lw[s1_row_r] && cw[row_up]);
    nb_mask[1] = !at_left && !lw[s1_row_r];
    nb_mask[2] = !at_left && !at_bot && !lw[row_dn] && !(lw[s1_row_r] && cw[row_dn]);
    nb_mask[3] = !at_top && !cw[row_up];
    nb_mask[4] = !at_bot && !cw[row_dn];
    nb_mask[5] = !at_right && !at_top && !rw[row_up] && !(rw[s1_row_r] && cw[row_up]);
    nb_mask[6] = !at_right && !rw[s1_row_r];
    nb_mask[7] = !at_right && !at_bot && !rw[row_dn] && !(rw[s1_row_r] && cw[row_dn]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_valid_r <= '0;
      start_set_r <= 1'b0;
      start_col_r <= '0;
      start_row_r <= '0;
      dest_set_r  <= 1'b0;
      dest_col_r  <= '0;
      dest_row_r  <= '0;
    end else if (s1_go) begin
      if (do_clear) begin
        col_valid_r <= '0;
      end else if (do_write) begin
        col_valid_r[s1_col_r] <= 1'b1;
      end
      start_set_r <= start_set_nxt;
      start_col_r <= start_col_nxt;
      start_row_r <= start_row_nxt;
      dest_set_r  <= dest_set_nxt;
      dest_col_r  <= dest_col_nxt;
      dest_row_r  <= dest_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && do_write) begin
      byp_col_r  <= s1_col_r;
      byp_data_r <= col_post;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go) begin
      out_mask_r <= nb_mask;
      out_blk_r  <= cw[s1_row_r];
      out_sv_r   <= start_set_nxt;
      out_sc_r   <= start_col_nxt;
      out_sr_r   <= start_row_nxt;
      out_dv_r   <= dest_set_nxt;
      out_dc_r   <= dest_col_nxt;
      out_dr_r   <= dest_row_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.neighbour_mask = out_mask_r;
  assign out_ch.cell_blocked   = out_blk_r;
  assign out_ch.start_valid    = out_sv_r;
  assign out_ch.start_column   = out_sc_r;
  assign out_ch.start_row      = out_sr_r;
  assign out_ch.dest_valid     = out_dv_r;
  assign out_ch.dest_column    = out_dc_r;
  assign out_ch.dest_row       = out_dr_r;

endmodule
